/* rtl/vrtd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ready-to-drive controller package
// Shared constants, register indexes, sequence codes and the types that pass
// between the front part, the queue and the back part.
// ----------------------------------------------------------------------------
package vrtd_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_BRAKE_LIMIT          = 3'd0;
  localparam logic [2:0] REG_APPS_FAULT_THRESHOLD = 3'd1;
  localparam logic [2:0] REG_START_HOLD_MS        = 3'd2;
  localparam logic [2:0] REG_BUZZ_MS              = 3'd3;
  localparam logic [2:0] REG_FAULT_PERSIST_MS     = 3'd4;
  localparam logic [2:0] REG_TORQUE_INVERT        = 3'd5;
  localparam logic [2:0] REG_DEBUG_PERIOD_MS      = 3'd6;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // Register reset values
  localparam logic [9:0]  RST_BRAKE_LIMIT          = 10'd204;
  localparam logic [10:0] RST_APPS_FAULT_THRESHOLD = 11'd102;
  localparam logic [15:0] RST_START_HOLD_MS        = 16'd2000;
  localparam logic [15:0] RST_BUZZ_MS              = 16'd2000;
  localparam logic [15:0] RST_FAULT_PERSIST_MS     = 16'd100;
  localparam logic        RST_TORQUE_INVERT        = 1'b0;
  localparam logic [15:0] RST_DEBUG_PERIOD_MS      = 16'd50;

  // Sequence states
  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_BUZZ  = 2'd2;
  localparam logic [1:0] MODE_DRIVE = 2'd3;

  // BMS permission frame
  localparam logic [28:0] BMS_ID      = 29'h186040F3;
  localparam logic [3:0]  BMS_MIN_LEN = 4'd7;
  localparam logic [7:0]  BMS_OK_BYTE = 8'h50;

  // Redundant sensor scaling 50/33 and torque gain
  localparam int SCALE_NUM   = 50;
  localparam int SCALE_DEN   = 33;
  localparam int GAIN_SHIFT  = 4;
  localparam int DIFF_W      = 11;
  localparam int TORQUE_W    = 16;

  typedef struct packed {
    logic [9:0]  brake_limit;
    logic [10:0] apps_fault_threshold;
    logic [15:0] start_hold_ms;
    logic [15:0] buzz_ms;
    logic [15:0] fault_persist_ms;
    logic        torque_invert;
    logic [15:0] debug_period_ms;
  } cfg_t;

  // One classified sample as it waits between front and back
  typedef struct packed {
    logic                       pressed;
    logic                       start;
    logic                       bms_ok;
    logic                       over_limit;
    logic [DIFF_W-1:0]          diff_sat;
    logic signed [TORQUE_W-1:0] torque;
    logic [31:0]                now_ms;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

/* rtl/vrtd_sample_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel carrying one sensor sample and its optional BMS frame.
// ----------------------------------------------------------------------------
interface vrtd_sample_if #(
  parameter int ADC_BITS = 10
);
  logic                valid;
  logic                ready;
  logic [ADC_BITS-1:0] apps_main;
  logic [ADC_BITS-1:0] apps_redundant;
  logic [ADC_BITS-1:0] brake_level;
  logic                start_req;
  logic                bms_msg_valid;
  logic [28:0]         bms_msg_id;
  logic [3:0]          bms_msg_len;
  logic [7:0]          bms_msg_byte6;
  logic [31:0]         now_ms;

  modport source (
    output valid, apps_main, apps_redundant, brake_level, start_req,
           bms_msg_valid, bms_msg_id, bms_msg_len, bms_msg_byte6, now_ms,
    input  ready
  );

  modport sink (
    input  valid, apps_main, apps_redundant, brake_level, start_req,
           bms_msg_valid, bms_msg_id, bms_msg_len, bms_msg_byte6, now_ms,
    output ready
  );
endinterface

/* rtl/vrtd_result_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the indicator and torque outputs of one sample.
// ----------------------------------------------------------------------------
interface vrtd_result_if;
  logic               valid;
  logic               ready;
  logic               stop_lamp;
  logic               buzzer_on;
  logic               drive_lamp;
  logic [1:0]         vehicle_state;
  logic               torque_send;
  logic signed [15:0] torque_cmd;
  logic               debug_send;
  logic [10:0]        apps_diff;
  logic               fault_active;

  modport source (
    output valid, stop_lamp, buzzer_on, drive_lamp, vehicle_state, torque_send,
           torque_cmd, debug_send, apps_diff, fault_active,
    input  ready
  );

  modport sink (
    input  valid, stop_lamp, buzzer_on, drive_lamp, vehicle_state, torque_send,
           torque_cmd, debug_send, apps_diff, fault_active,
    output ready
  );
endinterface

/* rtl/vrtd_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample classifier
// Registers each sample with a reciprocal estimate of the scaled redundant
// reading, then finishes the scaling and works out the brake, pedal
// plausibility, BMS and torque terms for the queue.
// ----------------------------------------------------------------------------
module vrtd_front import vrtd_pkg::*; #(
  parameter int ADC_BITS = 10
) (
  input  logic    clk,
  input  logic    rst,
  vrtd_sample_if.sink smp,
  input  cfg_t    cfg,
  input  q_stat_t q_stat,
  output logic    push,
  output entry_t  push_entry
);

  // Reciprocal of 33/50 with enough fraction bits that the estimate is at
  // most one below the true quotient.
  localparam int K      = ADC_BITS + 2;
  localparam int RW     = K + 1;
  localparam int PW     = ADC_BITS + RW;
  localparam int SW     = ADC_BITS + 1;
  localparam int XW     = ADC_BITS + 6;
  localparam int CW     = (SW > DIFF_W) ? SW : DIFF_W;
  localparam int TW     = (SW + GAIN_SHIFT > 17) ? SW + GAIN_SHIFT : 17;
  localparam logic [RW-1:0] RECIP = RW'((SCALE_NUM * (64'd1 << K)) / SCALE_DEN);
  localparam logic [CW-1:0] DIFF_MAX   = CW'((1 << DIFF_W) - 1);
  localparam logic [TW-1:0] TORQUE_POS = TW'(32767);
  localparam logic [TW-1:0] TORQUE_NEG = TW'(32768);

  logic                s_valid;
  logic [ADC_BITS-1:0] s_main;
  logic [ADC_BITS-1:0] s_red;
  logic [SW-1:0]       s_est;
  logic [ADC_BITS-1:0] s_brake;
  logic                s_start;
  logic                s_bms_ok;
  logic [31:0]         s_now;

  logic [PW-1:0] product;
  logic          take;

  logic [XW-1:0] red_x;
  logic [XW-1:0] est_x;
  logic [XW-1:0] rem;
  logic [SW-1:0] scaled;
  logic [SW-1:0] diff;
  logic [SW:0]   pedal_sum;
  logic [TW-1:0] torque_mag;
  logic [TORQUE_W-1:0] torque_val;

  assign smp.ready = !s_valid || !q_stat.full;
  assign take      = smp.valid && smp.ready;
  assign product   = PW'(smp.apps_redundant) * PW'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (smp.ready) begin
      s_valid <= smp.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s_main   <= smp.apps_main;
      s_red    <= smp.apps_redundant;
      s_est    <= SW'(product >> K);
      s_brake  <= smp.brake_level;
      s_start  <= smp.start_req;
      s_bms_ok <= smp.bms_msg_valid && (smp.bms_msg_id == BMS_ID) &&
                  (smp.bms_msg_len >= BMS_MIN_LEN) &&
                  (smp.bms_msg_byte6 == BMS_OK_BYTE);
      s_now    <= smp.now_ms;
    end
  end

  always_comb begin
    red_x  = XW'(s_red) * XW'(SCALE_NUM);
    est_x  = XW'(s_est) * XW'(SCALE_DEN);
    rem    = red_x - est_x;
    scaled = (rem >= XW'(SCALE_DEN)) ? s_est + SW'(1) : s_est;
    diff   = (SW'(s_main) > scaled) ? SW'(s_main) - scaled : scaled - SW'(s_main);

    pedal_sum  = (SW+1)'(s_main) + (SW+1)'(scaled);
    torque_mag = TW'(pedal_sum >> 1) << GAIN_SHIFT;
    if (!cfg.torque_invert) begin
      torque_val = (torque_mag > TORQUE_POS) ? TORQUE_POS[TORQUE_W-1:0]
                                             : torque_mag[TORQUE_W-1:0];
    end else begin
      torque_val = (torque_mag > TORQUE_NEG) ? TORQUE_NEG[TORQUE_W-1:0]
                                             : -torque_mag[TORQUE_W-1:0];
    end

    push_entry.pressed    = s_brake > ADC_BITS'(cfg.brake_limit);
    push_entry.start      = s_start;
    push_entry.bms_ok     = s_bms_ok;
    push_entry.over_limit = CW'(diff) > CW'(cfg.apps_fault_threshold);
    push_entry.diff_sat   = (CW'(diff) > DIFF_MAX) ? DIFF_MAX[DIFF_W-1:0]
                                                   : DIFF_W'(diff);
    push_entry.torque     = torque_val;
    push_entry.now_ms     = s_now;
  end

  assign push = s_valid && !q_stat.full;

endmodule

/* rtl/vrtd_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Classified sample queue
// Two-entry queue between the classifier and the sequencer.
// ----------------------------------------------------------------------------
module vrtd_queue import vrtd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  entry_t  push_entry,
  input  logic    pop,
  output entry_t  head,
  output q_stat_t q_stat
);

  entry_t     slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  assign head         = slots[rd_ptr];
  assign q_stat.full  = count == 2'd2;
  assign q_stat.empty = count == 2'd0;

endmodule

/* rtl/vrtd_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ready-to-drive sequencer
// Runs the idle, start held, buzzer and drive sequence with the pedal fault
// timer and the debug period, and holds the result in an output register.
// ----------------------------------------------------------------------------
module vrtd_back import vrtd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  entry_t  head,
  input  q_stat_t q_stat,
  output logic    pop,
  vrtd_result_if.source res
);

  logic [1:0]  mode;
  logic [31:0] mode_entry_time;
  logic [31:0] fault_begin_time;
  logic        fault_pending;
  logic        bms_permit;
  logic [31:0] last_report_time;
  logic        out_valid;

  logic [1:0]  mode_next;
  logic [31:0] mode_entry_time_next;
  logic [31:0] fault_begin_time_next;
  logic        fault_pending_next;
  logic        bms_permit_next;
  logic [31:0] last_report_time_next;
  logic        send;
  logic        dbg;
  logic [31:0] since_entry;
  logic [31:0] fault_start;

  assign pop = !q_stat.empty && (!out_valid || res.ready);

  always_comb begin
    mode_next             = mode;
    mode_entry_time_next  = mode_entry_time;
    fault_begin_time_next = fault_begin_time;
    fault_pending_next    = fault_pending;
    bms_permit_next       = bms_permit || head.bms_ok;
    last_report_time_next = last_report_time;
    send                  = 1'b0;
    dbg                   = 1'b0;
    since_entry           = head.now_ms - mode_entry_time;
    fault_start           = fault_pending ? fault_begin_time : head.now_ms;

    case (mode)
      MODE_IDLE: begin
        if (head.start && head.pressed) begin
          mode_next            = MODE_START;
          mode_entry_time_next = head.now_ms;
        end
      end
      MODE_START: begin
        if (!head.start || !head.pressed) begin
          mode_next = MODE_IDLE;
        end else if (bms_permit_next && (since_entry >= 32'(cfg.start_hold_ms))) begin
          mode_next            = MODE_BUZZ;
          mode_entry_time_next = head.now_ms;
          bms_permit_next      = 1'b0;
        end
      end
      MODE_BUZZ: begin
        if (since_entry >= 32'(cfg.buzz_ms)) begin
          mode_next = MODE_DRIVE;
        end
      end
      MODE_DRIVE: begin
        if (head.over_limit) begin
          if ((head.now_ms - fault_start) >= 32'(cfg.fault_persist_ms)) begin
            // Persistent disagreement: drop out of drive with no torque.
            mode_next             = MODE_IDLE;
            fault_begin_time_next = 32'd0;
            fault_pending_next    = 1'b0;
          end else begin
            fault_begin_time_next = fault_start;
            fault_pending_next    = 1'b1;
            send                  = 1'b1;
          end
        end else begin
          fault_begin_time_next = 32'd0;
          fault_pending_next    = 1'b0;
          send                  = 1'b1;
        end
      end
      default: begin
        mode_next = MODE_IDLE;
      end
    endcase

    if ((head.now_ms - last_report_time) >= 32'(cfg.debug_period_ms)) begin
      last_report_time_next = head.now_ms;
      dbg                   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= MODE_IDLE;
      mode_entry_time  <= 32'd0;
      fault_begin_time <= 32'd0;
      fault_pending    <= 1'b0;
      bms_permit       <= 1'b0;
      last_report_time <= 32'd0;
      out_valid        <= 1'b0;
    end else begin
      if (pop) begin
        mode             <= mode_next;
        mode_entry_time  <= mode_entry_time_next;
        fault_begin_time <= fault_begin_time_next;
        fault_pending    <= fault_pending_next;
        bms_permit       <= bms_permit_next;
        last_report_time <= last_report_time_next;
        out_valid        <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res.stop_lamp     <= head.pressed;
      res.buzzer_on     <= mode_next == MODE_BUZZ;
      res.drive_lamp    <= mode_next == MODE_DRIVE;
      res.vehicle_state <= mode_next;
      res.torque_send   <= send;
      res.torque_cmd    <= send ? head.torque : '0;
      res.debug_send    <= dbg;
      res.apps_diff     <= head.diff_sat;
      res.fault_active  <= fault_pending_next;
    end
  end

  assign res.valid = out_valid;

endmodule

/* rtl/vehicle_ready_to_drive_controller_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vehicle ready-to-drive controller
// Start sequence, pedal plausibility, torque command, brake light and debug
// strobe, one result for every sensor sample.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake        Carries
//  smp      in   valid / ready    pedal, brake, start button, BMS frame, time
//  res      out  valid / ready    indicators, state, torque, debug, pedal diff
//  cfg      in   cfg_we only      register index and write data
//
//  One sample per cycle sustained while results are taken. A sample passes
//  three registers: the reciprocal multiplier register, the two-entry queue
//  and the output register of the sequencer, in that order, before its
//  result is presented.
//  A stalled result holds the sequencer; the classifier stops once the
//  queue is full. Reset is synchronous and clears all control state and the
//  configuration registers to their defaults at once.
// ----------------------------------------------------------------------------
module vehicle_ready_to_drive_controller_unit import vrtd_pkg::*; #(
  parameter int ADC_BITS = 10
) (
  input  logic                   clk,
  input  logic                   rst,
  vrtd_sample_if.sink            smp,
  vrtd_result_if.source          res,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t    cfg;
  q_stat_t q_stat;
  logic    push;
  logic    pop;
  entry_t  push_entry;
  entry_t  head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.brake_limit          <= RST_BRAKE_LIMIT;
      cfg.apps_fault_threshold <= RST_APPS_FAULT_THRESHOLD;
      cfg.start_hold_ms        <= RST_START_HOLD_MS;
      cfg.buzz_ms              <= RST_BUZZ_MS;
      cfg.fault_persist_ms     <= RST_FAULT_PERSIST_MS;
      cfg.torque_invert        <= RST_TORQUE_INVERT;
      cfg.debug_period_ms      <= RST_DEBUG_PERIOD_MS;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BRAKE_LIMIT:          cfg.brake_limit          <= cfg_data[9:0];
        REG_APPS_FAULT_THRESHOLD: cfg.apps_fault_threshold <= cfg_data[10:0];
        REG_START_HOLD_MS:        cfg.start_hold_ms        <= cfg_data;
        REG_BUZZ_MS:              cfg.buzz_ms              <= cfg_data;
        REG_FAULT_PERSIST_MS:     cfg.fault_persist_ms     <= cfg_data;
        REG_TORQUE_INVERT:        cfg.torque_invert        <= cfg_data[0];
        REG_DEBUG_PERIOD_MS:      cfg.debug_period_ms      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  vrtd_front #(
    .ADC_BITS (ADC_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .smp        (smp),
    .cfg        (cfg),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  vrtd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  vrtd_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .res    (res)
  );

  // Torque is only ever commanded from the drive state.
  a_torque_in_drive: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.torque_send |-> res.drive_lamp && (res.vehicle_state == MODE_DRIVE))
    else $error("torque command outside drive");

  a_no_torque_value: assert property (@(posedge clk) disable iff (rst)
    res.valid && !res.torque_send |-> res.torque_cmd == 16'sd0)
    else $error("torque value without a command");

  // A pending pedal fault exists only while driving.
  a_fault_in_drive: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.fault_active |-> res.drive_lamp)
    else $error("pedal fault timed outside drive");

  a_buzzer_state: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.buzzer_on == (res.vehicle_state == MODE_BUZZ)) &&
                  !(res.buzzer_on && res.drive_lamp))
    else $error("buzzer indicator disagrees with state");

  a_queue_status: assert property (@(posedge clk) disable iff (rst)
    !(q_stat.full && q_stat.empty) && !(pop && q_stat.empty) && !(push && q_stat.full))
    else $error("queue status or handshake inconsistent");

endmodule
